// ----- rtl/core/tcpq_pkg.sv -----
`timescale 1ns / 1ps

package tcpq_pkg;

  // Defaults for the top-level parameters
  localparam int QUEUE_DEPTH_DEFAULT = 16;
  localparam int TICKET_BITS_DEFAULT = 16;

  // Fixed field widths
  localparam int AGE_W        = 8;
  localparam int TAG_W        = 32;
  localparam int TICKET_OUT_W = 16;
  localparam int STATUS_W     = 3;

  // Reset values
  localparam logic [AGE_W-1:0] AGE_THRESHOLD_RESET = 8'd60;
  localparam int               TICKET_RESET        = 1;

  // Request codes
  localparam logic MODE_ARRIVAL = 1'b0;
  localparam logic MODE_SERVE   = 1'b1;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_QUEUED_PRIO = 3'd0;
  localparam logic [STATUS_W-1:0] ST_QUEUED_REG  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_REJECT_FULL = 3'd2;
  localparam logic [STATUS_W-1:0] ST_SERVED_PRIO = 3'd3;
  localparam logic [STATUS_W-1:0] ST_SERVED_REG  = 3'd4;

  // Classified request handed from front to back
  typedef struct packed {
    logic                    mode;
    logic                    prio;
    logic [TICKET_OUT_W-1:0] ticket;
    logic [AGE_W-1:0]        age;
    logic [TAG_W-1:0]        tag;
  } cmd_t;

  // One stored customer
  typedef struct packed {
    logic [TICKET_OUT_W-1:0] ticket;
    logic [AGE_W-1:0]        age;
    logic [TAG_W-1:0]        tag;
  } entry_t;

endpackage

// ----- rtl/core/tcpq_ram.sv -----
`timescale 1ns / 1ps

module tcpq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- rtl/core/tcpq_front.sv -----
`timescale 1ns / 1ps

module tcpq_front
  import tcpq_pkg::*;
#(
  parameter int TICKET_BITS = TICKET_BITS_DEFAULT
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic             mode,
  input  logic [AGE_W-1:0] age,
  input  logic [TAG_W-1:0] customer_tag,
  input  logic             cfg_we,
  input  logic [AGE_W-1:0] cfg_wdata,
  input  logic             q_full,
  output logic             busy,
  output logic             push,
  output cmd_t             cmd
);

  localparam int TW = (TICKET_BITS > TICKET_OUT_W) ? TICKET_BITS : TICKET_OUT_W;

  logic [AGE_W-1:0]       age_threshold;
  logic [TICKET_BITS-1:0] ticket_ctr;
  logic [TW-1:0]          ticket_wide;

  // Hold off new items while the command queue is full
  assign busy = q_full;
  assign push = start && !busy;

  // Classify the item and attach the drawn ticket
  always_comb begin
    ticket_wide = TW'(ticket_ctr);
    cmd.mode    = mode;
    cmd.prio    = (age >= age_threshold);
    cmd.ticket  = ticket_wide[TICKET_OUT_W-1:0];
    cmd.age     = age;
    cmd.tag     = customer_tag;
  end

  // Threshold register and ticket counter; every arrival draws a ticket
  always_ff @(posedge clk) begin
    if (rst) begin
      age_threshold <= AGE_THRESHOLD_RESET;
      ticket_ctr    <= TICKET_BITS'(TICKET_RESET);
    end else begin
      if (cfg_we) begin
        age_threshold <= cfg_wdata;
      end
      if (push && mode == MODE_ARRIVAL) begin
        ticket_ctr <= ticket_ctr + 1'b1;
      end
    end
  end

endmodule

// ----- rtl/core/tcpq_cmd_queue.sv -----
`timescale 1ns / 1ps

module tcpq_cmd_queue
  import tcpq_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  input  logic pop,
  output logic full,
  output logic valid,
  output cmd_t head
);

  cmd_t       slots [2];
  logic       rd_ptr;
  logic       wr_ptr;
  logic [1:0] count;

  assign full  = (count == 2'd2);
  assign valid = (count != 2'd0);
  assign head  = slots[rd_ptr];

  // Store pushed items
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

// ----- rtl/core/tcpq_back.sv -----
`timescale 1ns / 1ps

module tcpq_back
  import tcpq_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cmd_valid,
  input  cmd_t                    cmd,
  output logic                    cmd_pop,
  output logic                    done,
  output logic [STATUS_W-1:0]     status,
  output logic                    served,
  output logic [TICKET_OUT_W-1:0] ticket,
  output logic [AGE_W-1:0]        served_age,
  output logic [TAG_W-1:0]        served_tag
);

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int EW = $bits(entry_t);

  typedef enum logic [1:0] {
    B_IDLE = 2'b01,
    B_READ = 2'b10
  } back_state_t;

  back_state_t state;
  back_state_t state_next;

  logic [AW-1:0] p_rd_ptr, p_wr_ptr, r_rd_ptr, r_wr_ptr;
  logic [CW-1:0] p_count, r_count;
  logic          sel_prio;

  logic          is_arrival, p_full, r_full, tgt_full;
  logic          p_we, r_we, p_re, r_re;
  entry_t        wr_entry;
  logic [EW-1:0] p_rd_raw, r_rd_raw;
  entry_t        rd_entry;

  // Queue storage
  tcpq_ram #(.WIDTH(EW), .DEPTH(QUEUE_DEPTH)) u_prio_ram (
    .clk     (clk),
    .wr_en   (p_we),
    .wr_addr (p_wr_ptr),
    .wr_data (wr_entry),
    .rd_en   (p_re),
    .rd_addr (p_rd_ptr),
    .rd_data (p_rd_raw)
  );

  tcpq_ram #(.WIDTH(EW), .DEPTH(QUEUE_DEPTH)) u_reg_ram (
    .clk     (clk),
    .wr_en   (r_we),
    .wr_addr (r_wr_ptr),
    .wr_data (wr_entry),
    .rd_en   (r_re),
    .rd_addr (r_rd_ptr),
    .rd_data (r_rd_raw)
  );

  // Decode the head command
  always_comb begin
    cmd_pop    = (state == B_IDLE) && cmd_valid;
    is_arrival = (cmd.mode == MODE_ARRIVAL);
    p_full     = (p_count == CW'(QUEUE_DEPTH));
    r_full     = (r_count == CW'(QUEUE_DEPTH));
    tgt_full   = cmd.prio ? p_full : r_full;
    p_we       = cmd_pop && is_arrival && cmd.prio && !p_full;
    r_we       = cmd_pop && is_arrival && !cmd.prio && !r_full;
    p_re       = cmd_pop && !is_arrival && (p_count != '0);
    r_re       = cmd_pop && !is_arrival && (p_count == '0) && (r_count != '0);
    wr_entry.ticket = cmd.ticket;
    wr_entry.age    = cmd.age;
    wr_entry.tag    = cmd.tag;
    rd_entry   = sel_prio ? entry_t'(p_rd_raw) : entry_t'(r_rd_raw);
  end

  // A removing serve waits in B_READ for the registered read
  always_comb begin
    state_next = state;
    unique case (state)
      B_IDLE: begin
        if (p_re || r_re) begin
          state_next = B_READ;
        end
      end
      B_READ: begin
        state_next = B_IDLE;
      end
      default: begin
        state_next = B_IDLE;
      end
    endcase
  end

  // Pointers, counts and result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= B_IDLE;
      p_rd_ptr <= '0;
      p_wr_ptr <= '0;
      p_count  <= '0;
      r_rd_ptr <= '0;
      r_wr_ptr <= '0;
      r_count  <= '0;
      done     <= 1'b0;
    end else begin
      state <= state_next;
      if (p_we) begin
        p_wr_ptr <= (p_wr_ptr == AW'(QUEUE_DEPTH - 1)) ? '0 : p_wr_ptr + 1'b1;
        p_count  <= p_count + 1'b1;
      end
      if (r_we) begin
        r_wr_ptr <= (r_wr_ptr == AW'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        r_count  <= r_count + 1'b1;
      end
      if (p_re) begin
        p_rd_ptr <= (p_rd_ptr == AW'(QUEUE_DEPTH - 1)) ? '0 : p_rd_ptr + 1'b1;
        p_count  <= p_count - 1'b1;
      end
      if (r_re) begin
        r_rd_ptr <= (r_rd_ptr == AW'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        r_count  <= r_count - 1'b1;
      end
      done <= (cmd_pop && !(p_re || r_re)) || (state == B_READ);
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (p_re || r_re) begin
      sel_prio <= p_re;
    end
    if (state == B_READ) begin
      status     <= sel_prio ? ST_SERVED_PRIO : ST_SERVED_REG;
      served     <= 1'b1;
      ticket     <= rd_entry.ticket;
      served_age <= rd_entry.age;
      served_tag <= rd_entry.tag;
    end else if (cmd_pop) begin
      if (is_arrival) begin
        status <= tgt_full ? ST_REJECT_FULL : (cmd.prio ? ST_QUEUED_PRIO : ST_QUEUED_REG);
        ticket <= cmd.ticket;
      end else begin
        status <= ST_SERVED_REG;
        ticket <= '0;
      end
      served     <= 1'b0;
      served_age <= '0;
      served_tag <= '0;
    end
  end

endmodule

// ----- rtl/core/two_class_priority_queue_core.sv -----
`timescale 1ns / 1ps

// Two-class strict-priority scheduler. An item is taken at a clock edge
// with start high and busy low: an arrival (mode 0) draws the next ticket
// and goes to the priority FIFO when its age is at least age_threshold,
// else to the regular FIFO, or is rejected if that FIFO is full; a serve
// (mode 1) removes the priority head if any, else the regular head. Taken
// items wait in a two-entry command queue, so busy rises only when that
// queue is full. Each item yields exactly one result, shown for one cycle
// with done high; the receiver cannot stall, so it must capture every
// strobe. An arrival or a serve that finds both FIFOs empty shows its
// result in the cycle after it leaves the command queue; a removing serve
// reads its entry from a registered-read RAM and registers its result in
// B_READ, where no item leaves the command queue. Rate: one arrival per
// cycle outside B_READ. The user must write age_threshold (reset 60) with
// cfg_we while no work is pending; the core itself does not enforce this.

module two_class_priority_queue_core
  import tcpq_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT,
  parameter int TICKET_BITS = TICKET_BITS_DEFAULT
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  output logic                    busy,
  input  logic                    mode,
  input  logic [AGE_W-1:0]        age,
  input  logic [TAG_W-1:0]        customer_tag,
  input  logic                    cfg_we,
  input  logic [AGE_W-1:0]        cfg_wdata,
  output logic                    done,
  output logic [STATUS_W-1:0]     status,
  output logic                    served,
  output logic [TICKET_OUT_W-1:0] ticket,
  output logic [AGE_W-1:0]        served_age,
  output logic [TAG_W-1:0]        served_tag
);

  logic push, q_full, q_valid, q_pop;
  cmd_t push_cmd, head_cmd;

  // Accept and classify
  tcpq_front #(.TICKET_BITS(TICKET_BITS)) u_front (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .mode         (mode),
    .age          (age),
    .customer_tag (customer_tag),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .q_full       (q_full),
    .busy         (busy),
    .push         (push),
    .cmd          (push_cmd)
  );

  // Decouple front from back
  tcpq_cmd_queue u_cmd_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (q_pop),
    .full     (q_full),
    .valid    (q_valid),
    .head     (head_cmd)
  );

  // Execute against the two FIFOs
  tcpq_back #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_back (
    .clk        (clk),
    .rst        (rst),
    .cmd_valid  (q_valid),
    .cmd        (head_cmd),
    .cmd_pop    (q_pop),
    .done       (done),
    .status     (status),
    .served     (served),
    .ticket     (ticket),
    .served_age (served_age),
    .served_tag (served_tag)
  );

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
  import tcpq_pkg::*;

  localparam int DEPTH       = QUEUE_DEPTH_DEFAULT;
  localparam int TKT_W       = TICKET_BITS_DEFAULT;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic [STATUS_W-1:0]     status;
    logic                    served;
    logic [TICKET_OUT_W-1:0] ticket;
    logic [AGE_W-1:0]        served_age;
    logic [TAG_W-1:0]        served_tag;
  } outcome_t;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    start = 1'b0;
  logic                    busy;
  logic                    mode = MODE_ARRIVAL;
  logic [AGE_W-1:0]        age = '0;
  logic [TAG_W-1:0]        customer_tag = '0;
  logic                    cfg_we = 1'b0;
  logic [AGE_W-1:0]        cfg_wdata = '0;
  logic                    done;
  logic [STATUS_W-1:0]     status;
  logic                    served;
  logic [TICKET_OUT_W-1:0] ticket;
  logic [AGE_W-1:0]        served_age;
  logic [TAG_W-1:0]        served_tag;

  // Scheduler mirror: both waiting lines, ticket counter and threshold
  entry_t           prio_line[$];
  entry_t           regular_line[$];
  logic [TKT_W-1:0] ticket_ctr = TKT_W'(TICKET_RESET);
  logic [AGE_W-1:0] threshold_q = AGE_THRESHOLD_RESET;

  outcome_t pending_results[$];
  int       mismatch_count = 0;
  int       sender_gap_pct = 0;

  two_class_priority_queue_core dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .mode         (mode),
    .age          (age),
    .customer_tag (customer_tag),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .done         (done),
    .status       (status),
    .served       (served),
    .ticket       (ticket),
    .served_age   (served_age),
    .served_tag   (served_tag)
  );

  always #1 clk = ~clk;

  // Work out what one accepted request does to the queues and what it reports
  function automatic outcome_t schedule_request(logic m, logic [AGE_W-1:0] a,
                                                logic [TAG_W-1:0] t);
    outcome_t   res;
    entry_t     ent;
    logic       to_prio;
    res = '0;
    if (m == MODE_ARRIVAL) begin
      to_prio    = (a >= threshold_q);
      ent.ticket = TICKET_OUT_W'(ticket_ctr);
      ent.age    = a;
      ent.tag    = t;
      res.ticket = TICKET_OUT_W'(ticket_ctr);
      ticket_ctr = ticket_ctr + 1'b1;
      if (to_prio && prio_line.size() < DEPTH) begin
        prio_line.push_back(ent);
        res.status = ST_QUEUED_PRIO;
      end else if (!to_prio && regular_line.size() < DEPTH) begin
        regular_line.push_back(ent);
        res.status = ST_QUEUED_REG;
      end else begin
        res.status = ST_REJECT_FULL;
      end
    end else begin
      res.status = ST_SERVED_REG;
      if (prio_line.size() != 0) begin
        ent        = prio_line.pop_front();
        res.status = ST_SERVED_PRIO;
        res.served = 1'b1;
      end else if (regular_line.size() != 0) begin
        ent        = regular_line.pop_front();
        res.served = 1'b1;
      end
      if (res.served) begin
        res.ticket     = ent.ticket;
        res.served_age = ent.age;
        res.served_tag = ent.tag;
      end
    end
    return res;
  endfunction

  function automatic void report_mismatch(string what, outcome_t exp_r, outcome_t got_r);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) begin
      $display("MISMATCH %s at %0t: exp st=%0d sv=%0d tkt=%0h age=%0d tag=%08h",
               what, $realtime, exp_r.status, exp_r.served, exp_r.ticket,
               exp_r.served_age, exp_r.served_tag);
      $display("                   got st=%0d sv=%0d tkt=%0h age=%0d tag=%08h",
               got_r.status, got_r.served, got_r.ticket, got_r.served_age,
               got_r.served_tag);
    end
  endfunction

  // Compare each strobed result with the oldest expected one
  always @(posedge clk) begin
    outcome_t got_r;
    outcome_t exp_r;
    if (!rst && done !== 1'b0) begin
      got_r = '{status, served, ticket, served_age, served_tag};
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", '0, got_r);
      end else begin
        exp_r = pending_results.pop_front();
        if (got_r !== exp_r) begin
          report_mismatch("result", exp_r, got_r);
        end
      end
    end
  end

  // Present one item, hold it until taken, then record its expected result
  task automatic send_item(logic m, logic [AGE_W-1:0] a, logic [TAG_W-1:0] t);
    while ($urandom_range(0, 99) < sender_gap_pct) begin
      @(negedge clk);
      start <= 1'b0;
    end
    @(negedge clk);
    start        <= 1'b1;
    mode         <= m;
    age          <= a;
    customer_tag <= t;
    do begin
      @(posedge clk);
    end while (busy !== 1'b0);
    pending_results.push_back(schedule_request(m, a, t));
  endtask

  // Stop sending and let every outstanding result come back
  task automatic drain_results();
    @(negedge clk);
    start <= 1'b0;
    while (pending_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (6) @(posedge clk);
  endtask

  task automatic set_threshold(logic [AGE_W-1:0] value);
    drain_results();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
    threshold_q = value;
  endtask

  // Empty queues, threshold boundary, field extremes, both thresholds' extremes
  task automatic test_directed();
    send_item(MODE_SERVE, 8'd0, '0);
    send_item(MODE_ARRIVAL, 8'd59, 32'h0000_0000);
    send_item(MODE_ARRIVAL, 8'd60, 32'hFFFF_FFFF);
    send_item(MODE_ARRIVAL, 8'd0, 32'hA5A5_A5A5);
    send_item(MODE_ARRIVAL, 8'd255, 32'h5A5A_5A5A);
    repeat (5) send_item(MODE_SERVE, 8'hFF, 32'hFFFF_FFFF);
    set_threshold(8'd0);
    send_item(MODE_ARRIVAL, 8'd0, 32'h1234_5678);
    send_item(MODE_ARRIVAL, 8'd1, 32'h8765_4321);
    send_item(MODE_SERVE, 8'd0, '0);
    send_item(MODE_SERVE, 8'd0, '0);
    set_threshold(8'd255);
    send_item(MODE_ARRIVAL, 8'd254, 32'h0000_0001);
    send_item(MODE_ARRIVAL, 8'd255, 32'h8000_0000);
    repeat (3) send_item(MODE_SERVE, 8'd0, '0);
  endtask

  // Bursts that lean toward arrivals or toward serves so both lines fill and drain
  task automatic test_random(int gap_pct, int item_total);
    int sent;
    int burst;
    int arrival_pct;
    int pick;
    int a;
    sender_gap_pct = gap_pct;
    sent = 0;
    while (sent < item_total) begin
      burst = $urandom_range(1, 24);
      pick  = $urandom_range(0, 2);
      arrival_pct = (pick == 0) ? 85 : (pick == 1) ? 50 : 15;
      repeat (burst) begin
        case ($urandom_range(0, 3))
          0: a = int'(threshold_q) + $urandom_range(0, 2) - 1;
          1: a = $urandom_range(0, 1) ? 255 : 0;
          default: a = $urandom_range(0, 255);
        endcase
        if (a < 0) a = 0;
        if (a > 255) a = 255;
        send_item(($urandom_range(0, 99) < arrival_pct) ? MODE_ARRIVAL : MODE_SERVE,
                  AGE_W'(a), $urandom);
        sent++;
      end
    end
  endtask

  // Fill both lines, keep arriving so full lines reject, then drain both
  task automatic test_full_lines();
    sender_gap_pct = 0;
    set_threshold(8'd128);
    while (prio_line.size() < DEPTH || regular_line.size() < DEPTH) begin
      send_item(MODE_ARRIVAL, AGE_W'($urandom_range(0, 255)), $urandom);
    end
    repeat (40) send_item(MODE_ARRIVAL, AGE_W'($urandom_range(0, 255)), $urandom);
    repeat (5) send_item(MODE_SERVE, 8'd0, '0);
    repeat (6) send_item(MODE_ARRIVAL, 8'd255, $urandom);
    repeat (2 * DEPTH + 1) send_item(MODE_SERVE, 8'd0, '0);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    sender_gap_pct = 25;
    test_directed();
    set_threshold(AGE_THRESHOLD_RESET);
    test_random(25, 300);
    set_threshold(8'd0);
    test_random(59, 250);
    set_threshold(8'd255);
    test_random(0, 200);
    set_threshold(AGE_W'($urandom_range(1, 254)));
    test_random(0, 250);
    test_full_lines();
    drain_results();

    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Hard stop well past the slowest legal run
  initial begin
    #5000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/tcpq_pkg.sv
rtl/core/tcpq_ram.sv
rtl/core/tcpq_front.sv
rtl/core/tcpq_cmd_queue.sv
rtl/core/tcpq_back.sv
rtl/core/two_class_priority_queue_core.sv
test/tb_top.sv
